// File: src/sppr_pkg.sv
// ----------------------------------------------------------------------------
// sppr_pkg
// Shared constants and types for the servo bus packet parser / responder.
// ----------------------------------------------------------------------------
package sppr_pkg;

    // Control table and parameter store sizes
    localparam int TABLE_DEPTH = 64;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int MAX_PARAMS  = 64;
    localparam int PRM_AW      = $clog2(MAX_PARAMS);
    localparam int MAX_READ    = 58;
    localparam int CNT_W       = $clog2(MAX_READ + 1);
    localparam int KW          = $clog2(MAX_PARAMS + 1);
    // start address (8 bits) plus an offset below 64 always fits
    localparam int EXT_AW      = 9;

    // Protocol bytes
    localparam logic [7:0] HDR_BYTE = 8'hFF;
    localparam logic [7:0] BCAST_ID = 8'hFE;
    localparam logic [7:0] ID_RESET = 8'h01;
    localparam logic [TBL_AW-1:0] ID_ADDR = TBL_AW'(3);
    localparam logic [7:0] STATUS_LEN_BASE = 8'h02;

    // Instructions
    localparam logic [7:0] OP_PING  = 8'h01;
    localparam logic [7:0] OP_READ  = 8'h02;
    localparam logic [7:0] OP_WRITE = 8'h03;
    localparam logic [7:0] OP_LAST  = 8'h06;
    localparam logic [7:0] OP_SYNCW = 8'h83;

    // Status error bits
    localparam logic [7:0] ERR_SUM   = 8'h10;
    localparam logic [7:0] ERR_INSTR = 8'h40;

    // Status packet header word positions
    localparam logic [2:0] POS_ID  = 3'd2;
    localparam logic [2:0] POS_LEN = 3'd3;
    localparam logic [2:0] POS_ERR = 3'd4;

    // Finished packet handed from parser to executor
    typedef struct packed {
        logic [7:0] op;
        logic [7:0] err;
        logic [7:0] total;
        logic       bcast;
    } cmd_t;

    typedef struct packed {
        logic              en;
        logic [EXT_AW-1:0] addr;
    } tbl_rd_t;

    typedef struct packed {
        logic              en;
        logic [TBL_AW-1:0] addr;
        logic [7:0]        data;
    } tbl_wr_t;

endpackage

// File: src/sppr_table.sv
// ----------------------------------------------------------------------------
// sppr_table
// Control table RAM with per-entry valid bits and a shadow of the ID entry.
// ----------------------------------------------------------------------------
module sppr_table import sppr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  tbl_rd_t    rd,
    input  tbl_wr_t    wr,
    output logic [7:0] rdata,
    output logic [7:0] id
);

    logic [7:0]             mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [7:0]             id_reg;
    logic [7:0]             mem_q;
    logic                   hit_q;
    logic                   idhit_q;
    logic [TBL_AW-1:0]      rd_idx;
    logic                   rd_in_range;

    assign rd_idx      = rd.addr[TBL_AW-1:0];
    assign rd_in_range = (rd.addr < EXT_AW'(TABLE_DEPTH));

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            mem_q   <= mem[rd_idx];
            hit_q   <= rd_in_range & valid_reg[rd_idx];
            idhit_q <= rd_in_range & (rd_idx == ID_ADDR);
        end
    end

    // unwritten entries read as their reset value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            id_reg    <= ID_RESET;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
            if (wr.addr == ID_ADDR) begin
                id_reg <= wr.data;
            end
        end
    end

    assign rdata = hit_q ? mem_q : (idhit_q ? ID_RESET : 8'h00);
    assign id    = id_reg;

endmodule

// File: src/sppr_parser.sv
// ----------------------------------------------------------------------------
// sppr_parser
// Packet framing, running checksum and parameter store.
// ----------------------------------------------------------------------------
module sppr_parser import sppr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic              in_func,
    input  logic [7:0]        in_byte,
    output logic              in_ready,
    input  logic              busy,
    input  logic [7:0]        tbl_id,
    input  logic [PRM_AW-1:0] prm_raddr,
    output logic [7:0]        prm_rdata,
    output logic              start,
    output cmd_t              cmd
);

    typedef enum logic [6:0] {
        PH_HDR1  = 7'b0000001,
        PH_HDR2  = 7'b0000010,
        PH_ID    = 7'b0000100,
        PH_LEN   = 7'b0001000,
        PH_INSTR = 7'b0010000,
        PH_PARAM = 7'b0100000,
        PH_SUM   = 7'b1000000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] op_reg, op_next;
    logic [7:0] total_reg, total_next;
    logic [7:0] pos_reg, pos_next;
    logic       bcast_reg, bcast_next;
    logic       accept;
    logic       byte_acc;
    logic       prm_we;
    logic       op_valid;
    logic [7:0] prm_mem [MAX_PARAMS];
    logic [7:0] prm_rdata_reg;

    assign in_ready = !busy;
    assign accept   = in_valid & in_ready;
    assign byte_acc = accept & !in_func;

    always_comb begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        op_next    = op_reg;
        total_next = total_reg;
        pos_next   = pos_reg;
        bcast_next = bcast_reg;
        if (accept && in_func) begin
            phase_next = PH_HDR1;
        end else if (byte_acc) begin
            case (phase_reg)
                PH_HDR1: begin
                    if (in_byte == HDR_BYTE) phase_next = PH_HDR2;
                end
                PH_HDR2: begin
                    phase_next = (in_byte == HDR_BYTE) ? PH_ID : PH_HDR1;
                end
                PH_ID: begin
                    // extra header words are skipped
                    if (in_byte != HDR_BYTE) begin
                        if (in_byte == tbl_id || in_byte == BCAST_ID) begin
                            bcast_next = (in_byte == BCAST_ID);
                            sum_next   = in_byte;
                            phase_next = PH_LEN;
                        end else begin
                            phase_next = PH_HDR1;
                        end
                    end
                end
                PH_LEN: begin
                    sum_next   = sum_reg + in_byte;
                    total_next = (in_byte > 8'd2) ? in_byte - 8'd2 : 8'd0;
                    phase_next = PH_INSTR;
                end
                PH_INSTR: begin
                    op_next    = in_byte;
                    sum_next   = sum_reg + in_byte;
                    pos_next   = 8'd0;
                    phase_next = (in_byte == OP_PING || total_reg == 8'd0) ? PH_SUM
                                                                          : PH_PARAM;
                end
                PH_PARAM: begin
                    sum_next = sum_reg + in_byte;
                    pos_next = pos_reg + 8'd1;
                    if (pos_next >= total_reg) phase_next = PH_SUM;
                end
                PH_SUM: begin
                    phase_next = PH_HDR1;
                end
                default: begin
                    phase_next = PH_HDR1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR1;
            sum_reg   <= 8'd0;
            op_reg    <= 8'd0;
            total_reg <= 8'd0;
            pos_reg   <= 8'd0;
            bcast_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            op_reg    <= op_next;
            total_reg <= total_next;
            pos_reg   <= pos_next;
            bcast_reg <= bcast_next;
        end
    end

    // parameter store: written while framing, read by the executor
    assign prm_we = byte_acc & (phase_reg == PH_PARAM) & (pos_reg < 8'(MAX_PARAMS));

    always_ff @(posedge aclk) begin
        if (prm_we) begin
            prm_mem[pos_reg[PRM_AW-1:0]] <= in_byte;
        end
        prm_rdata_reg <= prm_mem[prm_raddr];
    end

    assign prm_rdata = prm_rdata_reg;

    assign op_valid = ((op_reg >= OP_PING) && (op_reg <= OP_LAST)) || (op_reg == OP_SYNCW);

    assign start     = byte_acc & (phase_reg == PH_SUM);
    assign cmd.op    = op_reg;
    assign cmd.err   = ((in_byte != ~sum_reg) ? ERR_SUM : 8'h00) |
                       (op_valid ? 8'h00 : ERR_INSTR);
    assign cmd.total = total_reg;
    assign cmd.bcast = bcast_reg;

endmodule

// File: src/sppr_exec.sv
// ----------------------------------------------------------------------------
// sppr_exec
// Instruction sequencer: table writes and status packet generation.
// ----------------------------------------------------------------------------
module sppr_exec import sppr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  cmd_t              cmd,
    output logic              busy,
    output logic [PRM_AW-1:0] prm_raddr,
    input  logic [7:0]        prm_rdata,
    output tbl_rd_t           tbl_rd,
    output tbl_wr_t           tbl_wr,
    input  logic [7:0]        tbl_rdata,
    input  logic [7:0]        tbl_id,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_data,
    output logic              out_last
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PRM0  = 7'b0000010,
        ST_PRM1  = 7'b0000100,
        ST_WRITE = 7'b0001000,
        ST_HEAD  = 7'b0010000,
        ST_DATA  = 7'b0100000,
        ST_CSUM  = 7'b1000000
    } st_t;

    st_t               st_reg, st_next;
    logic [7:0]        op_reg, op_next;
    logic [7:0]        err_reg, err_next;
    logic [7:0]        total_reg, total_next;
    logic              bcast_reg, bcast_next;
    logic [7:0]        start_reg, start_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [EXT_AW-1:0] rd_addr_reg, rd_addr_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [EXT_AW-1:0] wr_addr_reg, wr_addr_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [2:0]        pos_reg, pos_next;
    logic [7:0]        sum_reg, sum_next;
    logic              ovalid_reg, ovalid_next;
    logic [7:0]        odata_reg, odata_next;
    logic              olast_reg, olast_next;
    logic              slot_free;
    logic              consume;
    logic [7:0]        head_byte;

    assign slot_free = !ovalid_reg || out_ready;
    assign consume   = rd_pend_reg && slot_free;

    always_comb begin
        case (pos_reg)
            POS_ID:  head_byte = tbl_id;
            POS_LEN: head_byte = 8'(cnt_reg) + STATUS_LEN_BASE;
            POS_ERR: head_byte = err_reg;
            default: head_byte = HDR_BYTE;
        endcase
    end

    always_comb begin
        st_next      = st_reg;
        op_next      = op_reg;
        err_next     = err_reg;
        total_next   = total_reg;
        bcast_next   = bcast_reg;
        start_next   = start_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        rd_addr_next = rd_addr_reg;
        rd_pend_next = rd_pend_reg;
        k_next       = k_reg;
        wr_addr_next = wr_addr_reg;
        wr_pend_next = wr_pend_reg;
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        prm_raddr    = '0;
        tbl_rd       = '0;
        tbl_wr       = '0;
        ovalid_next  = ovalid_reg & !out_ready;
        odata_next   = odata_reg;
        olast_next   = olast_reg;

        case (st_reg)
            ST_IDLE: begin
                if (start) begin
                    op_next    = cmd.op;
                    err_next   = cmd.err;
                    total_next = cmd.total;
                    bcast_next = cmd.bcast;
                    st_next    = ST_PRM0;
                end
            end
            ST_PRM0: begin
                start_next = prm_rdata;
                prm_raddr  = PRM_AW'(1);
                st_next    = ST_PRM1;
            end
            ST_PRM1: begin
                if (op_reg == OP_READ) begin
                    cnt_next = (prm_rdata > 8'(MAX_READ)) ? CNT_W'(MAX_READ)
                                                          : CNT_W'(prm_rdata);
                end else begin
                    cnt_next = '0;
                end
                rem_next     = cnt_next;
                rd_addr_next = EXT_AW'(start_reg);
                rd_pend_next = 1'b0;
                k_next       = KW'(1);
                wr_pend_next = 1'b0;
                pos_next     = '0;
                sum_next     = 8'd0;
                if (op_reg == OP_PING || op_reg == OP_READ) begin
                    st_next = ST_HEAD;
                end else if (op_reg == OP_WRITE) begin
                    st_next = ST_WRITE;
                end else begin
                    st_next = ST_IDLE;
                end
            end
            ST_WRITE: begin
                // param k is read in the cycle before its table write
                if (wr_pend_reg && wr_addr_reg < EXT_AW'(TABLE_DEPTH)) begin
                    tbl_wr.en   = 1'b1;
                    tbl_wr.addr = wr_addr_reg[TBL_AW-1:0];
                    tbl_wr.data = prm_rdata;
                end
                if (9'(k_reg) < 9'(total_reg) && 9'(k_reg) < 9'(MAX_PARAMS)) begin
                    prm_raddr    = k_reg[PRM_AW-1:0];
                    wr_pend_next = 1'b1;
                    wr_addr_next = EXT_AW'(start_reg) + EXT_AW'(k_reg) - EXT_AW'(1);
                    k_next       = k_reg + KW'(1);
                end else begin
                    wr_pend_next = 1'b0;
                    st_next      = bcast_reg ? ST_IDLE : ST_HEAD;
                end
            end
            ST_HEAD: begin
                if (slot_free) begin
                    ovalid_next = 1'b1;
                    odata_next  = head_byte;
                    olast_next  = 1'b0;
                    if (pos_reg >= POS_ID) sum_next = sum_reg + head_byte;
                    pos_next = pos_reg + 3'd1;
                    if (pos_reg == POS_ERR) st_next = ST_DATA;
                end
            end
            ST_DATA: begin
                if (consume) begin
                    ovalid_next = 1'b1;
                    odata_next  = tbl_rdata;
                    olast_next  = 1'b0;
                    sum_next    = sum_reg + tbl_rdata;
                end
                if (!rd_pend_reg || consume) begin
                    if (rem_reg != '0) begin
                        tbl_rd.en    = 1'b1;
                        tbl_rd.addr  = rd_addr_reg;
                        rd_addr_next = rd_addr_reg + EXT_AW'(1);
                        rem_next     = rem_reg - CNT_W'(1);
                        rd_pend_next = 1'b1;
                    end else begin
                        rd_pend_next = 1'b0;
                        st_next      = ST_CSUM;
                    end
                end
            end
            ST_CSUM: begin
                if (slot_free) begin
                    ovalid_next = 1'b1;
                    odata_next  = ~sum_reg;
                    olast_next  = 1'b1;
                    st_next     = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            rd_pend_reg <= 1'b0;
            wr_pend_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end else begin
            st_reg      <= st_next;
            rd_pend_reg <= rd_pend_next;
            wr_pend_reg <= wr_pend_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        err_reg     <= err_next;
        total_reg   <= total_next;
        bcast_reg   <= bcast_next;
        start_reg   <= start_next;
        cnt_reg     <= cnt_next;
        rem_reg     <= rem_next;
        rd_addr_reg <= rd_addr_next;
        k_reg       <= k_next;
        wr_addr_reg <= wr_addr_next;
        pos_reg     <= pos_next;
        sum_reg     <= sum_next;
        odata_reg   <= odata_next;
        olast_reg   <= olast_next;
    end

    assign busy      = (st_reg != ST_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign out_last  = olast_reg;

endmodule

// File: src/servo_packet_parser_responder_top.sv
// ----------------------------------------------------------------------------
// servo_packet_parser_responder_top
// Servo bus protocol 1.0 slave: packet parser and status responder.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one bus event per word: tuser = 0 with a received byte in
//   tdata, or tuser = 1 for a receive timeout (tdata ignored, framing resets).
//   m_axis carries the status packet one byte per word; tlast marks the
//   checksum byte that closes each packet.
//   Framing words are taken whenever the executor is idle. The checksum
//   word starts execution, and s_axis_tready stays low until the executor
//   is done: parameter fetch,
//     WRITE: each stored data byte is moved from parameter store to table,
//     answer: 6 + count words, with a bubble for the table RAM read ahead
//     of the data words.
//   So without stalls the longest hold-off comes from a WRITE of 63 stored
//   data bytes, then its status packet; the RAMs give one byte per cycle.
//   Output is registered; the next packet is accepted while the last
//   status word still waits on m_axis.
//   Reset (aresetn low, synchronous) returns framing to header search, clears
//   the output valid and makes the control table read as zeros with the
//   ID entry at one; no clearing sweep is needed.
//   A stall on m_axis_tready holds the current word and pauses status output.
// ----------------------------------------------------------------------------
module servo_packet_parser_responder_top import sppr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  logic       s_axis_tuser,   // [0] func
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] tx_byte
    output logic       m_axis_tlast
);

    logic              busy;
    logic              start;
    cmd_t              cmd;
    logic [PRM_AW-1:0] prm_raddr;
    logic [7:0]        prm_rdata;
    tbl_rd_t           tbl_rd;
    tbl_wr_t           tbl_wr;
    logic [7:0]        tbl_rdata;
    logic [7:0]        tbl_id;

    // framing, checksum, parameter store
    sppr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_func   (s_axis_tuser),
        .in_byte   (s_axis_tdata),
        .in_ready  (s_axis_tready),
        .busy      (busy),
        .tbl_id    (tbl_id),
        .prm_raddr (prm_raddr),
        .prm_rdata (prm_rdata),
        .start     (start),
        .cmd       (cmd)
    );

    // control table RAM; ID entry shadowed for id match and answers
    sppr_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (tbl_rd),
        .wr      (tbl_wr),
        .rdata   (tbl_rdata),
        .id      (tbl_id)
    );

    // instruction execution and status packet output
    sppr_exec u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .prm_raddr (prm_raddr),
        .prm_rdata (prm_rdata),
        .tbl_rd    (tbl_rd),
        .tbl_wr    (tbl_wr),
        .tbl_rdata (tbl_rdata),
        .tbl_id    (tbl_id),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// File: tb/sv/servo_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_status_checker
// Watches both stream channels of the servo bus responder. Every accepted
// input word runs through a local copy of the packet framer and executor,
// which queues the status words it should produce. Every accepted output
// word is compared against the oldest queued one.
// ----------------------------------------------------------------------------
module servo_status_checker import sppr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tuser,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic       m_axis_tlast,
    output int         fail_count,
    output int         pending_words,
    output int         words_checked,
    output int         packets_checked,
    output logic [7:0] node_id
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } status_word_t;

    typedef enum logic [2:0] {
        SEEK_HDR1, SEEK_HDR2, GET_ID, GET_LEN, GET_INSTR, GET_PARAM, GET_SUM
    } frame_phase_t;

    frame_phase_t phase;
    logic [7:0]   pkt_id;
    logic [7:0]   pkt_op;
    logic [7:0]   prm_total;
    logic [7:0]   prm_pos;
    logic [7:0]   run_sum;
    logic [7:0]   prm_mem [MAX_PARAMS];
    logic [7:0]   ctl_mem [TABLE_DEPTH];
    status_word_t status_q [$];
    int           n_fail;
    int           n_words;
    int           n_pkts;

    function automatic void push_word(input logic [7:0] data, input logic last);
        status_word_t w;
        w.data = data;
        w.last = last;
        status_q.push_back(w);
    endfunction

    function automatic logic [7:0] table_byte(input int addr);
        return (addr < TABLE_DEPTH) ? ctl_mem[addr] : 8'h00;
    endfunction

    function automatic void queue_short_status(input logic [7:0] err);
        logic [7:0] id;
        logic [7:0] csum;
        id   = ctl_mem[ID_ADDR];
        csum = id + STATUS_LEN_BASE + err;
        push_word(HDR_BYTE, 1'b0);
        push_word(HDR_BYTE, 1'b0);
        push_word(id, 1'b0);
        push_word(STATUS_LEN_BASE, 1'b0);
        push_word(err, 1'b0);
        push_word(~csum, 1'b1);
    endfunction

    // Checksum byte arrived: execute the held instruction.
    function automatic void run_packet(input logic [7:0] sum_byte);
        logic [7:0] err;
        logic [7:0] id;
        logic [7:0] csum;
        logic [7:0] v;
        int         start;
        int         cnt;
        phase = SEEK_HDR1;
        err   = 8'h00;
        if (sum_byte != ~run_sum)
            err |= ERR_SUM;
        if (!((pkt_op >= OP_PING && pkt_op <= OP_LAST) || pkt_op == OP_SYNCW))
            err |= ERR_INSTR;
        case (pkt_op)
            OP_PING: begin
                queue_short_status(err);
            end
            OP_READ: begin
                start = prm_mem[0];
                cnt   = prm_mem[1];
                if (cnt > MAX_READ)
                    cnt = MAX_READ;
                id   = ctl_mem[ID_ADDR];
                csum = id + err + 8'(cnt) + STATUS_LEN_BASE;
                push_word(HDR_BYTE, 1'b0);
                push_word(HDR_BYTE, 1'b0);
                push_word(id, 1'b0);
                push_word(8'(cnt) + STATUS_LEN_BASE, 1'b0);
                push_word(err, 1'b0);
                for (int i = 0; i < cnt; i++) begin
                    v    = table_byte(start + i);
                    csum = csum + v;
                    push_word(v, 1'b0);
                end
                push_word(~csum, 1'b1);
            end
            OP_WRITE: begin
                start = prm_mem[0];
                for (int k = 1; k < prm_total && k < MAX_PARAMS; k++) begin
                    if (start + k - 1 < TABLE_DEPTH)
                        ctl_mem[start + k - 1] = prm_mem[k];
                end
                if (pkt_id != BCAST_ID)
                    queue_short_status(err);
            end
            default: ;
        endcase
    endfunction

    function automatic void frame_event(input logic is_timeout, input logic [7:0] b);
        if (is_timeout) begin
            phase = SEEK_HDR1;
            return;
        end
        case (phase)
            SEEK_HDR1: begin
                if (b == HDR_BYTE)
                    phase = SEEK_HDR2;
            end
            SEEK_HDR2: begin
                phase = (b == HDR_BYTE) ? GET_ID : SEEK_HDR1;
            end
            GET_ID: begin
                // extra header bytes are skipped here
                if (b != HDR_BYTE) begin
                    if (b == ctl_mem[ID_ADDR] || b == BCAST_ID) begin
                        pkt_id  = b;
                        run_sum = b;
                        phase   = GET_LEN;
                    end else begin
                        phase = SEEK_HDR1;
                    end
                end
            end
            GET_LEN: begin
                run_sum   = run_sum + b;
                prm_total = (b > STATUS_LEN_BASE) ? b - STATUS_LEN_BASE : 8'h00;
                phase     = GET_INSTR;
            end
            GET_INSTR: begin
                pkt_op  = b;
                run_sum = run_sum + b;
                prm_pos = 8'h00;
                phase   = (b == OP_PING || prm_total == 8'h00) ? GET_SUM : GET_PARAM;
            end
            GET_PARAM: begin
                if (prm_pos < MAX_PARAMS)
                    prm_mem[prm_pos] = b;
                run_sum = run_sum + b;
                prm_pos = prm_pos + 8'h01;
                if (prm_pos >= prm_total)
                    phase = GET_SUM;
            end
            GET_SUM: begin
                run_packet(b);
            end
            default: phase = SEEK_HDR1;
        endcase
    endfunction

    function automatic void check_word(input logic [7:0] data, input logic last);
        status_word_t w;
        if (last)
            n_pkts++;
        if (status_q.size() == 0) begin
            n_fail++;
            if (n_fail <= 10)
                $display("%0t: unexpected status word %h last %b", $realtime, data, last);
            return;
        end
        w = status_q.pop_front();
        n_words++;
        if (w.data !== data || w.last !== last) begin
            n_fail++;
            if (n_fail <= 10)
                $display("%0t: status word mismatch: expected %h last %b, got %h last %b",
                         $realtime, w.data, w.last, data, last);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase     = SEEK_HDR1;
            pkt_id    = 8'h00;
            pkt_op    = 8'h00;
            prm_total = 8'h00;
            prm_pos   = 8'h00;
            run_sum   = 8'h00;
            foreach (prm_mem[i])
                prm_mem[i] = 8'h00;
            foreach (ctl_mem[i])
                ctl_mem[i] = 8'h00;
            ctl_mem[ID_ADDR] = ID_RESET;
            status_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_word(m_axis_tdata, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                frame_event(s_axis_tuser, s_axis_tdata);
        end
        fail_count      <= n_fail;
        pending_words   <= status_q.size();
        words_checked   <= n_words;
        packets_checked <= n_pkts;
        node_id         <= ctl_mem[ID_ADDR];
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the servo bus packet parser / responder. Sends
// directed packets for every instruction and framing corner, then random
// well-formed, broken and noise traffic with random idling on both sides.
// Checking is done by servo_status_checker beside the block.
// ----------------------------------------------------------------------------
module testbench;
    import sppr_pkg::*;

    // instruction codes with no answer and no effect
    localparam logic [7:0] OP_NONE      = 8'h00;
    localparam logic [7:0] OP_REG_WRITE = 8'h04;
    localparam logic [7:0] OP_ACTION    = 8'h05;

    // where the id byte of a packet points
    typedef enum int {TO_SELF, TO_ALL, TO_OTHER} dest_t;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tuser  = 1'b0;
    logic       m_tready = 1'b0;
    wire        s_tready;
    wire        m_tvalid;
    wire  [7:0] m_tdata;
    wire        m_tlast;

    int         fail_count;
    int         pending_words;
    int         words_checked;
    int         packets_checked;
    logic [7:0] node_id;

    // parameter bytes of the next packet, index 0 first after the instruction
    logic [7:0] prm_buf [256];
    // both sides stop idling while set
    bit         quiet = 1'b0;
    int         ev_count;
    int         timeout_count;
    int         pkt_words;
    // receiver hold-off
    int         hold_left;
    bit         hold_done;

    servo_packet_parser_responder_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast)
    );

    servo_status_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_axis_tvalid   (s_tvalid),
        .s_axis_tready   (s_tready),
        .s_axis_tdata    (s_tdata),
        .s_axis_tuser    (s_tuser),
        .m_axis_tvalid   (m_tvalid),
        .m_axis_tready   (m_tready),
        .m_axis_tdata    (m_tdata),
        .m_axis_tlast    (m_tlast),
        .fail_count      (fail_count),
        .pending_words   (pending_words),
        .words_checked   (words_checked),
        .packets_checked (packets_checked),
        .node_id         (node_id)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #2_000_000;
        $display("timeout: run did not drain");
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: random ready, one long hold-off once a long answer is queued
    // so the block backs up into its input while the sender keeps offering.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && pending_words >= 24) begin
            m_tready  <= 1'b0;
            hold_left <= 400;
            hold_done <= 1'b1;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= 37);
        end
    end

    // One word on s_axis. Returns at the edge that accepted it, tvalid still
    // high, so a following word goes out back to back when no gap is drawn.
    task automatic send_word(input logic is_timeout, input logic [7:0] b);
        if (!quiet) begin
            while ($urandom_range(0, 99) < 37) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_timeout;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        ev_count++;
        if (is_timeout)
            timeout_count++;
    endtask

    task automatic scramble_prm();
        foreach (prm_buf[i])
            prm_buf[i] = 8'($urandom_range(0, 255));
    endtask

    // Full packet: FF FF [extra FF] id len instr params checksum. The id is
    // taken after the headers so a table write by the previous packet has
    // already reached node_id. cut_at >= 0 replaces body byte cut_at (id is 0)
    // with a receive timeout and stops there.
    task automatic send_packet(input dest_t dest, input logic [7:0] op,
                               input logic [7:0] len, input bit bad_sum,
                               input int extra_hdr, input int cut_at);
        logic [7:0] body [$];
        logic [7:0] id;
        logic [7:0] sum;
        int         nprm;
        nprm = (op == OP_PING || len <= STATUS_LEN_BASE) ? 0 : int'(len) - 2;
        send_word(1'b0, HDR_BYTE);
        send_word(1'b0, HDR_BYTE);
        repeat (extra_hdr)
            send_word(1'b0, HDR_BYTE);
        case (dest)
            TO_SELF: id = node_id;
            TO_ALL:  id = BCAST_ID;
            default: begin
                id = 8'($urandom_range(0, 253));
                if (id == node_id)
                    id = (id == 8'h00) ? 8'h01 : id - 8'h01;
            end
        endcase
        body.push_back(id);
        body.push_back(len);
        body.push_back(op);
        for (int i = 0; i < nprm; i++)
            body.push_back(prm_buf[i]);
        sum = 8'h00;
        foreach (body[i])
            sum = sum + body[i];
        sum = ~sum;
        if (bad_sum)
            sum = sum ^ 8'($urandom_range(1, 255));
        body.push_back(sum);
        pkt_words += body.size() + 2 + extra_hdr;
        foreach (body[i]) begin
            if (i == cut_at) begin
                send_word(1'b1, 8'($urandom_range(0, 255)));
                return;
            end
            send_word(1'b0, body[i]);
        end
    endtask

    task automatic send_read(input dest_t dest, input logic [7:0] addr,
                             input logic [7:0] cnt, input bit bad_sum);
        prm_buf[0] = addr;
        prm_buf[1] = cnt;
        send_packet(dest, OP_READ, 8'd4, bad_sum, 0, -1);
    endtask

    // data bytes come from prm_buf[1..ndata]
    task automatic send_write(input dest_t dest, input logic [7:0] addr,
                              input int ndata, input bit bad_sum);
        prm_buf[0] = addr;
        send_packet(dest, OP_WRITE, 8'(ndata + 3), bad_sum, 0, -1);
    endtask

    function automatic dest_t pick_dest();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return TO_SELF;
        if (r < 92)
            return TO_ALL;
        return TO_OTHER;
    endfunction

    function automatic logic [7:0] pick_addr();
        if ($urandom_range(0, 99) < 90)
            return 8'($urandom_range(0, 66));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_other_op();
        case ($urandom_range(0, 5))
            0:       return OP_REG_WRITE;
            1:       return OP_ACTION;
            2:       return OP_LAST;
            3:       return OP_SYNCW;
            4:       return OP_NONE;
            default: return 8'($urandom_range(7, 255));
        endcase
    endfunction

    // One random packet: mostly well formed, some cut short, some long.
    task automatic random_packet();
        logic [7:0] op;
        logic [7:0] len;
        int         pick;
        int         extra;
        bit         bad;
        pick  = $urandom_range(0, 99);
        extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
        bad   = ($urandom_range(0, 9) == 0);
        if (pick < 30) begin
            op  = OP_READ;
            prm_buf[0] = pick_addr();
            prm_buf[1] = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 16))
                                                      : 8'($urandom_range(0, 255));
            len = ($urandom_range(0, 99) < 85) ? 8'd4 : 8'($urandom_range(0, 8));
        end else if (pick < 55) begin
            op  = OP_WRITE;
            prm_buf[0] = pick_addr();
            len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 3))
                                              : 8'($urandom_range(3, 11));
        end else if (pick < 70) begin
            op  = OP_PING;
            len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 8)) : 8'd2;
        end else if (pick < 84) begin
            op  = pick_other_op();
            len = 8'($urandom_range(2, 7));
        end else if (pick < 99) begin
            // broken: timeout somewhere inside the body
            op  = ($urandom_range(0, 1) == 0) ? OP_READ : OP_WRITE;
            len = 8'($urandom_range(3, 8));
            send_packet(pick_dest(), op, len, bad, extra, $urandom_range(0, 5));
            return;
        end else begin
            // more parameters than the store holds
            op  = ($urandom_range(0, 1) == 0) ? OP_WRITE : pick_other_op();
            len = 8'($urandom_range(67, 72));
        end
        send_packet(pick_dest(), op, len, bad, extra, -1);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 19) == 0)
                send_word(1'b1, 8'($urandom_range(0, 255)));
            else if ($urandom_range(0, 99) < 40)
                send_word(1'b0, HDR_BYTE);
            else
                send_word(1'b0, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        logic [7:0] no_answer_ops [8];
        int         base;
        no_answer_ops = '{OP_REG_WRITE, OP_ACTION, OP_LAST, OP_SYNCW, OP_NONE,
                          8'h07, 8'h84, 8'hFF};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---------------- directed part ----------------
        scramble_prm();
        // first packet stores params 0 and 1, so later short packets read
        // only written entries; table head shows the reset id
        send_read(TO_SELF, 8'd0, 8'd8, 1'b0);
        send_packet(TO_SELF, OP_PING, 8'd2, 1'b0, 0, -1);
        // extra header bytes before the id, broadcast ping still answers
        send_packet(TO_ALL, OP_PING, 8'd2, 1'b0, 2, -1);
        // data extremes into the table
        prm_buf[1] = 8'h00;
        prm_buf[2] = 8'hFF;
        prm_buf[3] = 8'h55;
        prm_buf[4] = 8'hAA;
        send_write(TO_SELF, 8'd8, 4, 1'b0);
        send_read(TO_SELF, 8'd0, 8'hFF, 1'b0);      // count capped
        send_read(TO_SELF, 8'd40, 8'd58, 1'b0);     // runs past table end
        send_read(TO_SELF, 8'hFF, 8'd3, 1'b0);      // wholly outside table
        send_read(TO_SELF, 8'd5, 8'd0, 1'b0);       // zero count
        prm_buf[1] = 8'h11;
        prm_buf[2] = 8'h22;
        prm_buf[3] = 8'h33;
        send_write(TO_ALL, 8'd16, 3, 1'b0);         // broadcast write, silent
        send_write(TO_SELF, 8'd61, 5, 1'b1);        // bad sum, still written
        send_read(TO_SELF, 8'd56, 8'd8, 1'b1);      // bad sum read
        send_packet(TO_SELF, OP_PING, 8'd6, 1'b0, 0, -1);  // ping skips params
        send_packet(TO_SELF, OP_READ, 8'd2, 1'b0, 0, -1);  // reuses stored params
        foreach (no_answer_ops[i])
            send_packet(TO_SELF, no_answer_ops[i], 8'd4, 1'b0, 0, -1);
        send_packet(TO_OTHER, OP_PING, 8'd2, 1'b0, 0, -1); // foreign id
        send_packet(TO_SELF, OP_READ, 8'd4, 1'b0, 0, 3);   // timeout mid packet
        // own id becomes the broadcast id, then the header byte, then back
        prm_buf[1] = BCAST_ID;
        send_write(TO_SELF, 8'(ID_ADDR), 1, 1'b0);
        send_packet(TO_SELF, OP_PING, 8'd2, 1'b0, 0, -1);
        send_write(TO_SELF, 8'd20, 0, 1'b0);        // own id is broadcast: silent
        prm_buf[1] = HDR_BYTE;
        send_write(TO_ALL, 8'(ID_ADDR), 1, 1'b0);
        send_packet(TO_ALL, OP_PING, 8'd2, 1'b0, 0, -1);
        prm_buf[1] = ID_RESET;
        send_write(TO_ALL, 8'(ID_ADDR), 1, 1'b0);
        // long packet: 67 params, excess beyond the store only summed
        scramble_prm();
        prm_buf[4] = 8'h2A;                         // lands on the id entry
        send_write(TO_SELF, 8'd0, 66, 1'b0);
        send_read(TO_SELF, 8'd0, 8'd58, 1'b0);

        // ---------------- random part ----------------
        base = pkt_words;
        while (pkt_words - base < 70) begin
            quiet <= (pkt_words - base >= 20) && (pkt_words - base < 55);
            scramble_prm();
            if (node_id == BCAST_ID || node_id == HDR_BYTE) begin
                // an id nobody can address on its own: put a usable one back
                prm_buf[1] = 8'($urandom_range(0, 253));
                send_write(TO_ALL, 8'(ID_ADDR), 1, 1'b0);
            end else if ($urandom_range(0, 99) < 10) begin
                send_noise();
            end else begin
                random_packet();
            end
        end

        // ---------------- drain ----------------
        quiet    <= 1'b0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("Sent %0d bus words (%0d timeouts); checked %0d status words in %0d packets.",
                 ev_count, timeout_count, words_checked, packets_checked);
        $display({"Covered ping, read, write, silent and invalid opcodes, broadcast, ",
                  "bad sums, cut packets and id changes."});
        if (fail_count == 0 && pending_words == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
